### design/meter_frame_deframer_unit_defines.svh
// Assertion macros for the meter frame deframer.
// No dependencies; included by the top level only.
`ifndef METER_FRAME_DEFRAMER_UNIT_DEFINES_SVH
`define METER_FRAME_DEFRAMER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define MFD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define MFD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define MFD_ASSERT_IMP(lbl, ante, cons, msg)
`define MFD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### design/mfd_pkg.sv
// Shared widths, codes and types of the meter frame deframer.
// No dependencies.
package mfd_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned LEN_W     = 14;
	localparam int unsigned ADDR_W    = 16;
	localparam int unsigned STATUS_W  = 3;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DAT_W = 14;

	localparam logic [LEN_W-1:0]  MIN_USER_LEN   = LEN_W'(8);
	localparam logic [LEN_W-1:0]  HDR_LAST_IDX   = LEN_W'(3);
	localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'h68;
	localparam logic [BYTE_W-1:0] END_BYTE_RST   = 8'h16;
	localparam logic [LEN_W-1:0]  MAX_LEN_RST    = LEN_W'(1024);

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_CSUM_BAD  = 3'd1,
		ST_END_BAD   = 3'd2,
		ST_LEN_RANGE = 3'd3,
		ST_NO_START2 = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_START_BYTE = 2'd0,
		CFG_END_BYTE   = 2'd1,
		CFG_MAX_LEN    = 2'd2
	} cfg_idx_t;

	typedef enum logic [5:0] {
		PH_HUNT   = 6'b000001,
		PH_HEADER = 6'b000010,
		PH_START2 = 6'b000100,
		PH_USER   = 6'b001000,
		PH_CS     = 6'b010000,
		PH_END    = 6'b100000
	} phase_t;

	typedef struct packed {
		status_t             status;
		logic [BYTE_W-1:0]   control;
		logic [ADDR_W-1:0]   addr_a1;
		logic [ADDR_W-1:0]   addr_a2;
		logic [BYTE_W-1:0]   addr_a3;
		logic [BYTE_W-1:0]   afn;
		logic [BYTE_W-1:0]   seq;
		logic [LEN_W-1:0]    user_len;
		logic [BYTE_W-1:0]   received_sum;
	} result_t;

endpackage

### design/meter_frame_deframer_unit.sv
// Byte-serial deframer for 1376.1 style meter frames: one received byte per request,
// one result per frame (or per rejected header). A byte is registered on entry and
// then passes through the frame state machine and checksum adder, and the result is
// registered in the output register; a new byte is taken every cycle unless stalled.
// Input stalls only while a result waits in the output register and out_ready is low.
// Depends on mfd_pkg and meter_frame_deframer_unit_defines.svh.
`include "meter_frame_deframer_unit_defines.svh"

module meter_frame_deframer_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [mfd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mfd_pkg::CFG_DAT_W-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [mfd_pkg::BYTE_W-1:0]    rx_byte,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [mfd_pkg::STATUS_W-1:0]  status,
	output logic [mfd_pkg::BYTE_W-1:0]    control,
	output logic [mfd_pkg::ADDR_W-1:0]    addr_a1,
	output logic [mfd_pkg::ADDR_W-1:0]    addr_a2,
	output logic [mfd_pkg::BYTE_W-1:0]    addr_a3,
	output logic [mfd_pkg::BYTE_W-1:0]    afn,
	output logic [mfd_pkg::BYTE_W-1:0]    seq,
	output logic [mfd_pkg::LEN_W-1:0]     user_len,
	output logic [mfd_pkg::BYTE_W-1:0]    received_sum
);
	import mfd_pkg::*;

	// configuration
	logic [BYTE_W-1:0] start_byte_q, end_byte_q;
	logic [LEN_W-1:0]  max_len_q;

	// input stage
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;

	// frame state
	phase_t            phase_q, phase_d;
	logic [LEN_W-1:0]  byte_cnt_q, byte_cnt_d, byte_cnt_inc;
	logic [5:0]        len_lo_q, len_lo_d;
	logic [LEN_W-1:0]  user_len_q, user_len_d, hdr_len;
	logic [BYTE_W-1:0] run_sum_q, run_sum_d, csum_q, csum_d;
	logic [BYTE_W-1:0] control_q, control_d, a3_q, a3_d, afn_q, afn_d, seq_q, seq_d;
	logic [ADDR_W-1:0] a1_q, a1_d, a2_q, a2_d;

	// result
	logic              out_valid_q;
	result_t           res_q, res_d;
	logic              emit_s1, with_fields, out_free, fire_s1;
	status_t           res_status;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= START_BYTE_RST;
			end_byte_q   <= END_BYTE_RST;
			max_len_q    <= MAX_LEN_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_START_BYTE: start_byte_q <= cfg_data[BYTE_W-1:0];
				CFG_END_BYTE:   end_byte_q   <= cfg_data[BYTE_W-1:0];
				CFG_MAX_LEN:    max_len_q    <= cfg_data[LEN_W-1:0];
				default:        ;
			endcase
		end
	end

	assign out_free = !out_valid_q || out_ready;
	assign fire_s1  = valid_s1 && out_free;
	assign in_ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	assign hdr_len      = {byte_s1, len_lo_q};
	assign byte_cnt_inc = byte_cnt_q + LEN_W'(1);

	always_comb begin
		phase_d    = phase_q;
		byte_cnt_d = byte_cnt_q;
		len_lo_d   = len_lo_q;
		user_len_d = user_len_q;
		run_sum_d  = run_sum_q;
		csum_d     = csum_q;
		control_d  = control_q;
		a1_d       = a1_q;
		a2_d       = a2_q;
		a3_d       = a3_q;
		afn_d      = afn_q;
		seq_d      = seq_q;
		emit_s1    = 1'b0;
		res_status = ST_OK;
		case (phase_q)
			PH_HUNT: begin
				if (byte_s1 == start_byte_q) begin
					phase_d    = PH_HEADER;
					byte_cnt_d = '0;
				end
			end
			PH_HEADER: begin
				if (byte_cnt_q == LEN_W'(0)) begin
					len_lo_d = byte_s1[7:2];
				end else if (byte_cnt_q == LEN_W'(1)) begin
					user_len_d = hdr_len;
				end
				if (byte_cnt_q == LEN_W'(1) &&
				    (hdr_len < MIN_USER_LEN || hdr_len > max_len_q)) begin
					emit_s1    = 1'b1;
					res_status = ST_LEN_RANGE;
					phase_d    = PH_HUNT;
				end else if (byte_cnt_q == HDR_LAST_IDX) begin
					byte_cnt_d = '0;
					phase_d    = PH_START2;
				end else begin
					byte_cnt_d = byte_cnt_inc;
				end
			end
			PH_START2: begin
				if (byte_s1 != start_byte_q) begin
					emit_s1    = 1'b1;
					res_status = ST_NO_START2;
					phase_d    = PH_HUNT;
				end else begin
					byte_cnt_d = '0;
					run_sum_d  = '0;
					phase_d    = PH_USER;
				end
			end
			PH_USER: begin
				run_sum_d = run_sum_q + byte_s1;
				if (byte_cnt_q[LEN_W-1:3] == '0) begin
					case (byte_cnt_q[2:0])
						3'd0:    control_d = byte_s1;
						3'd1:    a1_d      = {a1_q[15:8], byte_s1};
						3'd2:    a1_d      = {byte_s1, a1_q[7:0]};
						3'd3:    a2_d      = {a2_q[15:8], byte_s1};
						3'd4:    a2_d      = {byte_s1, a2_q[7:0]};
						3'd5:    a3_d      = byte_s1;
						3'd6:    afn_d     = byte_s1;
						default: seq_d     = byte_s1;
					endcase
				end
				byte_cnt_d = byte_cnt_inc;
				if (byte_cnt_inc >= user_len_q) begin
					phase_d = PH_CS;
				end
			end
			PH_CS: begin
				csum_d  = byte_s1;
				phase_d = PH_END;
			end
			PH_END: begin
				emit_s1 = 1'b1;
				phase_d = PH_HUNT;
				if (byte_s1 != end_byte_q) begin
					res_status = ST_END_BAD;
				end else if (csum_q != run_sum_q) begin
					res_status = ST_CSUM_BAD;
				end else begin
					res_status = ST_OK;
				end
			end
			default: phase_d = PH_HUNT;
		endcase
	end

	// results of rejected headers carry only the status and the length
	assign with_fields = (phase_q == PH_END);

	always_comb begin
		res_d.status       = res_status;
		res_d.control      = with_fields ? control_q : '0;
		res_d.addr_a1      = with_fields ? a1_q : '0;
		res_d.addr_a2      = with_fields ? a2_q : '0;
		res_d.addr_a3      = with_fields ? a3_q : '0;
		res_d.afn          = with_fields ? afn_q : '0;
		res_d.seq          = with_fields ? seq_q : '0;
		res_d.user_len     = user_len_d;
		res_d.received_sum = with_fields ? csum_q : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HUNT;
			byte_cnt_q <= '0;
		end else if (fire_s1) begin
			phase_q    <= phase_d;
			byte_cnt_q <= byte_cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			len_lo_q   <= len_lo_d;
			user_len_q <= user_len_d;
			run_sum_q  <= run_sum_d;
			csum_q     <= csum_d;
			control_q  <= control_d;
			a1_q       <= a1_d;
			a2_q       <= a2_d;
			a3_q       <= a3_d;
			afn_q      <= afn_d;
			seq_q      <= seq_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= fire_s1 && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && fire_s1 && emit_s1) begin
			res_q <= res_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = res_q.status;
	assign control      = res_q.control;
	assign addr_a1      = res_q.addr_a1;
	assign addr_a2      = res_q.addr_a2;
	assign addr_a3      = res_q.addr_a3;
	assign afn          = res_q.afn;
	assign seq          = res_q.seq;
	assign user_len     = res_q.user_len;
	assign received_sum = res_q.received_sum;

	`MFD_ASSERT_NEXT(a_emit_lands, fire_s1 && emit_s1, out_valid_q, "result lost")
	`MFD_ASSERT_IMP(a_err_clear, out_valid && status > ST_END_BAD, received_sum == '0, "error fields")
	`MFD_ASSERT_IMP(a_len_ok, out_valid && status != ST_LEN_RANGE, user_len >= MIN_USER_LEN, "short len")

endmodule
